// ----- hdl/assert_macros.svh -----
// Assertion macros used by the bridge table top level.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge outside reset
`define BTOR_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bridge table check failed");

// consequent must hold after the antecedent, checked with non-overlapping implication
`define BTOR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bridge table sequencing check failed");

`endif

// ----- hdl/btor_pkg.sv -----
// Shared types, codes and defaults of the bridge table with owner revocation.
// No dependencies; used by btor_seq and bridge_table_owner_revoke.
`timescale 1ns / 1ps
`default_nettype none

package btor_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int MAX_DEPS_DEF   = 4;
	localparam int KEY_BITS_DEF   = 48;
	localparam int OWNER_BITS_DEF = 16;

	// widths of the word fields on the ports
	localparam int KEY_W      = 48;
	localparam int OWNER_W    = 16;
	localparam int DEP_FIELDS = 4;
	localparam int DCNT_W     = 3;
	localparam int RCNT_W     = 5;
	localparam logic [RCNT_W-1:0] COUNT_MAX = 5'd31;

	localparam int S_DATA_W = 136;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 8;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REVOKE = 2'd2,
		OP_REBIND = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DISP_GUEST    = 2'd0,
		DISP_REJECT   = 2'd1,
		DISP_FRONTEND = 2'd2
	} disp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                                opcode;
		logic [KEY_W-1:0]                   key;
		logic                               start_active;
		logic [DCNT_W-1:0]                  dep_count;
		logic [DEP_FIELDS-1:0][OWNER_W-1:0] dep_owner;
		logic [OWNER_W-1:0]                 revoke_owner;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [RCNT_W-1:0] revoked_count;
		disp_t             dispatch;
	} res_t;

	// sequencer handshake towards the port logic
	typedef struct packed {
		logic idle;
		logic res_valid;
	} seq_stat_t;

endpackage

`default_nettype wire

// ----- hdl/bridge_table_owner_revoke.sv -----
// Top level of the bridge table with owner revocation: stream ports, result
// register, record RAM and sequencer. Uses btor_pkg, btor_ram, btor_seq.
`timescale 1ns / 1ps
`default_nettype none

// Keyed table of ENTRIES call bridges, one word in, one word out. Every
// operation sweeps the record RAM once, one entry read per cycle; then add
// and rebind take an update step, the result is handed to the output
// register once it is free, and the sequencer returns to idle. Revoke
// writes each hit entry back in the cycle after its read. Valid marks are
// flip-flops cleared by reset, so the table is usable straight out of reset
// with no clearing pass. A new word is taken as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
`include "assert_macros.svh"

module bridge_table_owner_revoke #(
	parameter int ENTRIES    = btor_pkg::ENTRIES_DEF,
	parameter int MAX_DEPS   = btor_pkg::MAX_DEPS_DEF,
	parameter int KEY_BITS   = btor_pkg::KEY_BITS_DEF,
	parameter int OWNER_BITS = btor_pkg::OWNER_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// key, start_active, dep_count, dep_owner_0..3, revoke_owner, zero pad
	input  wire logic [btor_pkg::S_DATA_W-1:0]   s_tdata,
	// opcode
	input  wire logic [btor_pkg::S_USER_W-1:0]   s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// dispatch, revoked_count, ok
	output logic [btor_pkg::M_DATA_W-1:0]        m_tdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int REC_W = KEY_BITS + 1 + btor_pkg::DCNT_W + MAX_DEPS * OWNER_BITS;

	btor_pkg::req_t      req;
	btor_pkg::res_t      res, res_q;
	btor_pkg::seq_stat_t stat;
	logic                in_fire, res_take, m_tvalid_q;
	logic                rd_en, wr_en;
	logic [IDX_W-1:0]    rd_addr, wr_addr;
	logic [REC_W-1:0]    rd_data, wr_data;

	assign req.opcode       = btor_pkg::op_t'(s_tuser);
	assign req.key          = s_tdata[47:0];
	assign req.start_active = s_tdata[48];
	assign req.dep_count    = s_tdata[51:49];
	assign req.dep_owner[0] = s_tdata[67:52];
	assign req.dep_owner[1] = s_tdata[83:68];
	assign req.dep_owner[2] = s_tdata[99:84];
	assign req.dep_owner[3] = s_tdata[115:100];
	assign req.revoke_owner = s_tdata[131:116];

	assign s_tready = stat.idle;
	assign in_fire  = s_tvalid && s_tready;
	// result register refills as soon as the old word leaves
	assign res_take = stat.res_valid && (!m_tvalid_q || m_tready);

	btor_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (REC_W),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	btor_seq #(
		.ENTRIES    (ENTRIES),
		.MAX_DEPS   (MAX_DEPS),
		.KEY_BITS   (KEY_BITS),
		.OWNER_BITS (OWNER_BITS),
		.IDX_W      (IDX_W),
		.REC_W      (REC_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.req      (req),
		.res_take (res_take),
		.stat     (stat),
		.res      (res),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_take)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_take)
			res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

	`BTOR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`BTOR_ASSERT_ALWAYS(a_disp_code, !m_tvalid_q || res_q.dispatch == btor_pkg::DISP_GUEST || res_q.dispatch == btor_pkg::DISP_REJECT || res_q.dispatch == btor_pkg::DISP_FRONTEND)
	`BTOR_ASSERT_ALWAYS(a_one_kind, !m_tvalid_q || res_q.dispatch == btor_pkg::DISP_GUEST || res_q.revoked_count == '0)
	`BTOR_ASSERT_ALWAYS(a_fail_clean, !m_tvalid_q || res_q.ok || (res_q.revoked_count == '0 && res_q.dispatch == btor_pkg::DISP_GUEST))

endmodule

`default_nettype wire

// ----- hdl/btor_ram.sv -----
// Single-port-write, single-port-read synchronous RAM holding the entry records.
// Read data registered. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module btor_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/btor_seq.sv -----
// Operation sequencer: sweeps the record RAM, does key search, free slot search
// and owner revoke with write-back, then the final update for add and rebind. Uses btor_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btor_seq #(
	parameter int ENTRIES    = btor_pkg::ENTRIES_DEF,
	parameter int MAX_DEPS   = btor_pkg::MAX_DEPS_DEF,
	parameter int KEY_BITS   = btor_pkg::KEY_BITS_DEF,
	parameter int OWNER_BITS = btor_pkg::OWNER_BITS_DEF,
	parameter int IDX_W      = 4,
	parameter int REC_W      = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_fire,
	input  wire btor_pkg::req_t      req,
	input  wire logic                res_take,
	output btor_pkg::seq_stat_t      stat,
	output btor_pkg::res_t           res,
	output logic                     rd_en,
	output logic [IDX_W-1:0]         rd_addr,
	input  wire logic [REC_W-1:0]    rd_data,
	output logic                     wr_en,
	output logic [IDX_W-1:0]         wr_addr,
	output logic [REC_W-1:0]         wr_data
);

	// record layout: key | active | owner count | owners
	localparam int ACT_POS = KEY_BITS;
	localparam int CNT_LO  = KEY_BITS + 1;
	localparam int OWN_LO  = CNT_LO + btor_pkg::DCNT_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int DEP_LIM = (MAX_DEPS < btor_pkg::DEP_FIELDS) ? MAX_DEPS
		: btor_pkg::DEP_FIELDS;

	btor_pkg::state_t state_q, state_d;
	btor_pkg::req_t   req_q;

	logic [CNT_W-1:0]          issue_q;
	logic                      vld_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [ENTRIES-1:0]        valid_q;
	logic                      found_q, free_found_q, act_q;
	logic [IDX_W-1:0]          slot_q, free_q;
	logic [btor_pkg::RCNT_W-1:0] count_q;

	// fields of the record coming back from the RAM
	logic [KEY_BITS-1:0]             rec_key;
	logic                            rec_act;
	logic [btor_pkg::DCNT_W-1:0]     rec_cnt;
	logic                            rec_valid, key_hit, last_s1;
	logic [MAX_DEPS-1:0]             own_hit;
	logic                            dep_hit, revoke_hit;
	logic [KEY_BITS-1:0]             req_key;
	logic [OWNER_BITS-1:0]           req_owner;
	logic [btor_pkg::DCNT_W-1:0]     new_cnt;
	logic [MAX_DEPS*OWNER_BITS-1:0]  new_owners;
	logic                            upd_ok;

	assign rec_key   = rd_data[KEY_BITS-1:0];
	assign rec_act   = rd_data[ACT_POS];
	assign rec_cnt   = rd_data[OWN_LO-1:CNT_LO];
	assign rec_valid = valid_q[idx_s1];
	assign req_key   = KEY_BITS'(req_q.key);
	assign req_owner = OWNER_BITS'(req_q.revoke_owner);
	assign key_hit   = rec_valid && (rec_key == req_key);
	assign last_s1   = vld_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));

	for (genvar d = 0; d < MAX_DEPS; d++) begin : g_dep
		assign own_hit[d] = (btor_pkg::DCNT_W'(d) < rec_cnt)
			&& (rd_data[OWN_LO + d*OWNER_BITS +: OWNER_BITS] == req_owner);
		if (d < btor_pkg::DEP_FIELDS) begin : g_in
			assign new_owners[d*OWNER_BITS +: OWNER_BITS] =
				(btor_pkg::DCNT_W'(d) < new_cnt)
				? OWNER_BITS'(req_q.dep_owner[d]) : '0;
		end else begin : g_zero
			assign new_owners[d*OWNER_BITS +: OWNER_BITS] = '0;
		end
	end

	assign dep_hit    = |own_hit;
	assign revoke_hit = rec_valid && rec_act && dep_hit;
	assign new_cnt    = (req_q.dep_count > btor_pkg::DCNT_W'(DEP_LIM))
		? btor_pkg::DCNT_W'(DEP_LIM) : req_q.dep_count;
	// add needs a matching or a free entry, rebind a matching one
	assign upd_ok = (req_q.opcode == btor_pkg::OP_ADD) ? (found_q || free_found_q)
		: found_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btor_pkg::ST_IDLE:
				if (in_fire)
					state_d = btor_pkg::ST_SCAN;
			btor_pkg::ST_SCAN:
				if (last_s1) begin
					if (req_q.opcode == btor_pkg::OP_ADD
							|| req_q.opcode == btor_pkg::OP_REBIND)
						state_d = btor_pkg::ST_WRITE;
					else
						state_d = btor_pkg::ST_DONE;
				end
			btor_pkg::ST_WRITE:
				state_d = btor_pkg::ST_DONE;
			btor_pkg::ST_DONE:
				if (res_take)
					state_d = btor_pkg::ST_IDLE;
			default:
				state_d = btor_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		stat.idle      = (state_q == btor_pkg::ST_IDLE);
		stat.res_valid = (state_q == btor_pkg::ST_DONE);
		rd_en          = (state_q == btor_pkg::ST_SCAN) && (issue_q < CNT_W'(ENTRIES));
		rd_addr        = issue_q[IDX_W-1:0];
		wr_en          = 1'b0;
		wr_addr        = idx_s1;
		wr_data        = rd_data;
		res.dispatch      = btor_pkg::DISP_GUEST;
		res.revoked_count = '0;
		res.ok            = 1'b1;
		unique case (state_q)
			btor_pkg::ST_SCAN: begin
				// revoke write-back trails the read sweep by one entry
				wr_en = vld_s1 && (req_q.opcode == btor_pkg::OP_REVOKE) && revoke_hit;
				wr_data[ACT_POS] = 1'b0;
			end
			btor_pkg::ST_WRITE: begin
				wr_en   = upd_ok;
				wr_addr = found_q ? slot_q : free_q;
				wr_data = {new_owners, new_cnt,
					(req_q.opcode == btor_pkg::OP_ADD) ? req_q.start_active : 1'b1,
					req_key};
			end
			btor_pkg::ST_DONE: begin
				unique case (req_q.opcode)
					btor_pkg::OP_LOOKUP:
						res.dispatch = !found_q ? btor_pkg::DISP_FRONTEND
							: (act_q ? btor_pkg::DISP_GUEST : btor_pkg::DISP_REJECT);
					btor_pkg::OP_REVOKE:
						res.revoked_count = count_q;
					btor_pkg::OP_ADD, btor_pkg::OP_REBIND:
						res.ok = upd_ok;
					default:
						res.ok = 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= btor_pkg::ST_IDLE;
			issue_q      <= '0;
			vld_s1       <= 1'b0;
			valid_q      <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			count_q      <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (in_fire) begin
				issue_q      <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				count_q      <= '0;
			end else if (rd_en) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if (state_q == btor_pkg::ST_SCAN && vld_s1) begin
				if (key_hit && !found_q)
					found_q <= 1'b1;
				if (!rec_valid && !free_found_q)
					free_found_q <= 1'b1;
				if (req_q.opcode == btor_pkg::OP_REVOKE && revoke_hit
						&& count_q != btor_pkg::COUNT_MAX)
					count_q <= count_q + btor_pkg::RCNT_W'(1);
			end
			if (state_q == btor_pkg::ST_WRITE && wr_en)
				valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			req_q <= req;
		if (rd_en)
			idx_s1 <= rd_addr;
		if (state_q == btor_pkg::ST_SCAN && vld_s1) begin
			if (key_hit && !found_q) begin
				slot_q <= idx_s1;
				act_q  <= rec_act;
			end
			if (!rec_valid && !free_found_q)
				free_q <= idx_s1;
		end
	end

endmodule

`default_nettype wire
